// ===== design/yt_pkg.sv =====
// ----------------------------------------------------------------------------
// yt_pkg
// Shared types and constants for the Young tableau priority queue.
// ----------------------------------------------------------------------------
package yt_pkg;

  // key format and the empty marker
  localparam int KEY_W = 32;
  localparam logic signed [KEY_W-1:0] EMPTY_KEY = 32'sh7FFF_FFFF;

  // default grid size
  localparam int ROWS_MAX_DEF = 16;
  localparam int COLS_MAX_DEF = 16;

  // configuration registers
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 5'd16;
  localparam logic CFG_IDX_ROWS = 1'b0;
  localparam logic CFG_IDX_COLS = 1'b1;

  // command codes
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_SEARCH  = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_REFUSED = 2'd1;
  localparam logic [1:0] STS_EMPTY   = 2'd2;

  // compare unit result
  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

// ===== design/yt_ram.sv =====
// ----------------------------------------------------------------------------
// yt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module yt_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/yt_cmp.sv =====
// ----------------------------------------------------------------------------
// yt_cmp
// Shared signed key comparator used by every sift and search step.
// ----------------------------------------------------------------------------
module yt_cmp (
  input  logic signed [yt_pkg::KEY_W-1:0] a,
  input  logic signed [yt_pkg::KEY_W-1:0] b,
  output yt_pkg::cmp_res_t                res
);
  import yt_pkg::*;

  // one signed compare, three outcomes
  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
    res.gt = !res.eq && !res.lt;
  end

endmodule

// ===== design/young_tableau_priority_queue.sv =====
// ----------------------------------------------------------------------------
// young_tableau_priority_queue
// Sorted grid of signed keys with insert, extract-min and staircase search,
// run by a sequencer over one grid RAM and one shared comparator.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_cmd, in_key
//   out     | output    | out_valid/out_stall| out_status, out_value, out_found
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Each sift step makes two neighbor reads through the RAM read port, then
// compares and writes back; a search reads and compares each visited cell.
// After reset a clearing pass writes the marker to all ROWS_MAX*COLS_MAX
// cells, one per cycle, while in_stall is high.
// A result waits in the output register; the next beat is taken meanwhile,
// and its result waits until the pending one is taken.
// ----------------------------------------------------------------------------
module young_tableau_priority_queue #(
  parameter int ROWS_MAX = yt_pkg::ROWS_MAX_DEF,
  parameter int COLS_MAX = yt_pkg::COLS_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_cmd,
  input  logic signed [yt_pkg::KEY_W-1:0] in_key,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic signed [yt_pkg::KEY_W-1:0] out_value,
  output logic                            out_found,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [yt_pkg::CFG_W-1:0]        cfg_data
);
  import yt_pkg::*;

  localparam int DEPTH = ROWS_MAX * COLS_MAX;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int CW = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam logic [6:0] RMAX7 = 7'(ROWS_MAX);
  localparam logic [6:0] CMAX7 = 7'(COLS_MAX);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD0, ST_CHK0, ST_NB1, ST_NB2, ST_STEP, ST_FIN
  } state_t;

  state_t                   state_r;
  logic [CFG_W-1:0]         cfg_rows_r, cfg_cols_r;
  logic [AW-1:0]            clr_r;
  logic [1:0]               cmd_r;
  logic signed [KEY_W-1:0]  key_r;
  logic [RW-1:0]            r_r;
  logic [CW-1:0]            c_r;
  logic signed [KEY_W-1:0]  n1_r;
  logic                     n1_hit_r;
  logic [1:0]               res_status_r;
  logic signed [KEY_W-1:0]  res_value_r;
  logic                     res_found_r;
  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic signed [KEY_W-1:0]  out_value_r;
  logic                     out_found_r;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                               input logic [CW-1:0] col);
    return AW'(AW'(row) * AW'(COLS_MAX)) + AW'(col);
  endfunction

  // last row and column in use
  logic [6:0]    rows7, cols7;
  logic [RW-1:0] lr;
  logic [CW-1:0] lc;
  assign rows7 = {2'b00, cfg_rows_r};
  assign cols7 = {2'b00, cfg_cols_r};
  assign lr = (rows7 == 7'd0) ? '0 :
              (rows7 > RMAX7) ? RW'(ROWS_MAX - 1) : RW'(rows7 - 7'd1);
  assign lc = (cols7 == 7'd0) ? '0 :
              (cols7 > CMAX7) ? CW'(COLS_MAX - 1) : CW'(cols7 - 7'd1);

  // neighbor positions: up/left for insert, down/right for extract
  logic          is_ins;
  logic          nb1_ok, nb2_ok;
  logic [RW-1:0] nb1_row;
  logic [CW-1:0] nb2_col;
  assign is_ins  = (cmd_r == CMD_INSERT);
  assign nb1_ok  = is_ins ? (r_r != '0) : (r_r != lr);
  assign nb2_ok  = is_ins ? (c_r != '0) : (c_r != lc);
  assign nb1_row = !nb1_ok ? r_r : (is_ins ? r_r - 1'b1 : r_r + 1'b1);
  assign nb2_col = !nb2_ok ? c_r : (is_ins ? c_r - 1'b1 : c_r + 1'b1);

  // grid memory
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic signed [KEY_W-1:0] ram_wdata;
  logic signed [KEY_W-1:0] rdata;

  yt_ram #(.W(KEY_W), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // shared comparator
  logic signed [KEY_W-1:0] hole_val, cmp_b;
  cmp_res_t                cmp;
  logic                    better;
  assign hole_val = is_ins ? key_r : EMPTY_KEY;

  always_comb begin
    case (state_r)
      ST_CHK0: cmp_b = (cmd_r == CMD_SEARCH) ? key_r : EMPTY_KEY;
      ST_STEP: cmp_b = n1_hit_r ? n1_r : hole_val;
      default: cmp_b = hole_val;
    endcase
  end

  yt_cmp u_cmp (.a(rdata), .b(cmp_b), .res(cmp));
  assign better = is_ins ? cmp.gt : cmp.lt;

  // step decision
  logic                    mv2, move;
  logic signed [KEY_W-1:0] best_val;
  assign mv2      = nb2_ok && better;
  assign move     = n1_hit_r || mv2;
  assign best_val = mv2 ? rdata : n1_r;

  // memory ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr(r_r, c_r);
    ram_wdata = move ? best_val : hole_val;
    ram_raddr = cell_addr(r_r, c_r);
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = EMPTY_KEY;
      end
      ST_NB1:  ram_raddr = cell_addr(nb1_row, c_r);
      ST_NB2:  ram_raddr = cell_addr(r_r, nb2_col);
      ST_STEP: ram_we = 1'b1;
      default: ;
    endcase
  end

  logic in_acc;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cfg_rows_r  <= CFG_DIM_RESET;
      cfg_cols_r  <= CFG_DIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_ROWS: cfg_rows_r <= cfg_data;
          CFG_IDX_COLS: cfg_cols_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r        <= in_cmd;
            key_r        <= in_key;
            res_status_r <= STS_OK;
            res_value_r  <= '0;
            res_found_r  <= 1'b0;
            r_r          <= '0;
            c_r          <= '0;
            state_r      <= ST_RD0;
            case (in_cmd)
              CMD_INSERT: begin
                r_r <= lr;
                c_r <= lc;
                if (in_key == EMPTY_KEY) begin
                  res_status_r <= STS_REFUSED;
                  state_r      <= ST_FIN;
                end
              end
              CMD_EXTRACT: ;
              CMD_SEARCH: begin
                c_r <= lc;
                if (in_key == EMPTY_KEY) begin
                  state_r <= ST_FIN;
                end
              end
              default: state_r <= ST_FIN;
            endcase
          end
        end
        ST_RD0: state_r <= ST_CHK0;
        ST_CHK0: begin
          case (cmd_r)
            CMD_INSERT: begin
              if (!cmp.eq) begin
                res_status_r <= STS_REFUSED;
                state_r      <= ST_FIN;
              end else begin
                state_r <= ST_NB1;
              end
            end
            CMD_EXTRACT: begin
              if (cmp.eq) begin
                res_status_r <= STS_EMPTY;
                res_value_r  <= EMPTY_KEY;
                state_r      <= ST_FIN;
              end else begin
                res_value_r <= rdata;
                state_r     <= ST_NB1;
              end
            end
            default: begin
              // staircase walk from the top-right corner
              if (cmp.eq) begin
                res_found_r <= 1'b1;
                state_r     <= ST_FIN;
              end else if (cmp.gt) begin
                if (c_r == '0) begin
                  state_r <= ST_FIN;
                end else begin
                  c_r     <= c_r - 1'b1;
                  state_r <= ST_RD0;
                end
              end else if (r_r == lr) begin
                state_r <= ST_FIN;
              end else begin
                r_r     <= r_r + 1'b1;
                state_r <= ST_RD0;
              end
            end
          endcase
        end
        ST_NB1: state_r <= ST_NB2;
        ST_NB2: begin
          n1_r     <= rdata;
          n1_hit_r <= nb1_ok && better;
          state_r  <= ST_STEP;
        end
        ST_STEP: begin
          if (mv2) begin
            c_r     <= nb2_col;
            state_r <= ST_NB1;
          end else if (n1_hit_r) begin
            r_r     <= nb1_row;
            state_r <= ST_NB1;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_value_r  <= res_value_r;
            out_found_r  <= res_found_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_found  = out_found_r;

  // no result leaves during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r)
    else $error("result during clearing pass");

  // walk position stays inside the grid in use
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR && state_r != ST_IDLE) |-> r_r <= lr)
    else $error("row index outside grid");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR && state_r != ST_IDLE) |-> c_r <= lc)
    else $error("column index outside grid");

  // empty extract always carries the marker
  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STS_EMPTY) |-> out_value_r == EMPTY_KEY)
    else $error("empty status without marker value");

  // a found result is a search: OK status, zero value, never a refusal or empty
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == STS_OK && out_value_r == '0))
    else $error("found flag with non-search fields");

endmodule
